FILE: rtl/m4inv_pkg.sv
// Package for the 4x4 matrix inverse: microcode fields, program table and
// element address function. No dependencies.
package m4inv_pkg;

    localparam int ELEM_W = 32;
    localparam int COF_W  = 97;
    localparam int ACC_W  = 131;
    localparam int REM_W  = 132;
    localparam int MUL_W  = 33;
    localparam int PC_W   = 5;

    typedef enum logic [2:0] {
        OPA_NONE, OPA_A, OPA_PLO, OPA_PHI, OPA_ADJ0, OPA_ADJ1, OPA_ADJ2
    } t_opa;

    typedef enum logic [1:0] {ADR_S0, ADR_S1, ADR_S2, ADR_K} t_adr;
    typedef enum logic [1:0] {MD_NONE, MD_PROD, MD_M} t_mdst;
    typedef enum logic [1:0] {AC_NONE, AC_CLR, AC_TERM, AC_ADD} t_acc;
    typedef enum logic [1:0] {SH_0, SH_32, SH_64} t_sh;
    typedef enum logic [1:0] {K_NONE, K_CLR, K_INC} t_kop;
    typedef enum logic [2:0] {
        OP_NONE, OP_LDA, OP_STC, OP_DET, OP_NLD, OP_OVF, OP_DIV, OP_EMIT
    } t_op;
    typedef enum logic [2:0] {J_NONE, J_K5, J_K3, J_CI, J_D, J_ZERO} t_jmp;

    typedef struct packed {
        t_op       op;
        t_opa      opa;
        t_adr      adr;
        t_mdst     mdst;
        t_acc      acc;
        t_sh       sh;
        t_kop      kop;
        logic      ci_inc;
        logic      d_clr;
        logic      d_inc;
        t_jmp      jmp;
        logic [PC_W-1:0] target;
        logic      fin;
    } t_ucode;

    localparam t_ucode UC_NOP = '{OP_NONE, OPA_NONE, ADR_S0, MD_NONE, AC_NONE, SH_0,
                                  K_NONE, 1'b0, 1'b0, 1'b0, J_NONE, '0, 1'b0};

    function automatic t_ucode f_ucode(input logic [PC_W-1:0] pc);
        t_ucode u;
        u = UC_NOP;
        unique case (pc)
            5'd0: begin
                u.acc = AC_CLR; u.kop = K_CLR;
            end
            5'd1: begin
                u.op = OP_LDA; u.adr = ADR_S0;
            end
            5'd2: begin
                u.opa = OPA_A; u.adr = ADR_S1; u.mdst = MD_PROD;
            end
            5'd3: begin
                u.opa = OPA_PLO; u.adr = ADR_S2; u.mdst = MD_M;
            end
            5'd4: begin
                u.acc = AC_TERM; u.opa = OPA_PHI; u.adr = ADR_S2; u.mdst = MD_M;
            end
            5'd5: begin
                u.acc = AC_TERM; u.sh = SH_32; u.kop = K_INC;
                u.jmp = J_K5; u.target = 5'd1;
            end
            5'd6: begin
                u.op = OP_STC; u.ci_inc = 1'b1; u.jmp = J_CI; u.target = 5'd0;
            end
            5'd7: begin
                u.acc = AC_CLR; u.kop = K_CLR;
            end
            5'd8: begin
                u.opa = OPA_ADJ0; u.adr = ADR_K; u.mdst = MD_M;
            end
            5'd9: begin
                u.acc = AC_ADD; u.opa = OPA_ADJ1; u.adr = ADR_K; u.mdst = MD_M;
            end
            5'd10: begin
                u.acc = AC_ADD; u.sh = SH_32; u.opa = OPA_ADJ2; u.adr = ADR_K;
                u.mdst = MD_M;
            end
            5'd11: begin
                u.acc = AC_ADD; u.sh = SH_64; u.kop = K_INC;
                u.jmp = J_K3; u.target = 5'd8;
            end
            5'd12: begin
                u.op = OP_DET;
            end
            5'd13: begin
                u.op = OP_NLD; u.d_clr = 1'b1; u.jmp = J_ZERO; u.target = 5'd16;
            end
            5'd14: begin
                u.op = OP_OVF;
            end
            5'd15: begin
                u.op = OP_DIV; u.d_inc = 1'b1; u.jmp = J_D; u.target = 5'd15;
            end
            5'd16: begin
                u.op = OP_EMIT; u.ci_inc = 1'b1; u.jmp = J_CI; u.target = 5'd13;
                u.fin = 1'b1;
            end
            default: begin
                u = UC_NOP;
            end
        endcase
        return u;
    endfunction

    localparam logic [2:0] PERM [6][3] = '{
        '{3'd0, 3'd1, 3'd2}, '{3'd1, 3'd2, 3'd0}, '{3'd2, 3'd0, 3'd1},
        '{3'd0, 3'd2, 3'd1}, '{3'd2, 3'd1, 3'd0}, '{3'd1, 3'd0, 3'd2}
    };

    function automatic logic [1:0] f_skip(input logic [1:0] n, input logic [1:0] s);
        logic [1:0] r;
        r = (n < s) ? n : n + 2'd1;
        return r;
    endfunction

    function automatic logic [3:0] f_addr(input logic [3:0] ci, input logic [2:0] p,
                                          input logic [1:0] slot);
        logic [1:0] row;
        logic [1:0] col;
        logic [2:0] pi;
        pi  = (p < 3'd6) ? p : 3'd0;
        row = f_skip(slot, ci[1:0]);
        col = f_skip(PERM[pi][slot][1:0], ci[3:2]);
        return {row, col};
    endfunction

    function automatic logic f_term_neg(input logic [3:0] ci, input logic [2:0] p);
        logic odd;
        odd = (p >= 3'd3);
        return odd ^ ci[0] ^ ci[2];
    endfunction

endpackage

FILE: rtl/matrix4x4_inverse_top.sv
// 4x4 matrix inverse in Q16.16, microcoded over a shared 33x33 multiplier
// and a one-bit-per-cycle divider. Depends on m4inv_pkg.
//
//  channel | handshake          | fields
//  input   | start / busy       | i_elem_value
//  result  | o_valid (strobe)   | o_out_value, o_out_last, o_singular
//
// Elements load one per cycle while busy is low. After the sixteenth beat
// busy stays high through the cofactor, determinant and divide phases
// (the divide is skipped when singular), paced by the single multiplier and
// the bit-serial divider. Synchronous reset clears load count, sequencer
// and strobe. Results cannot be stalled.
module matrix4x4_inverse_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [m4inv_pkg::ELEM_W-1:0] i_elem_value,
    output logic                                o_valid,
    output logic signed [m4inv_pkg::ELEM_W-1:0] o_out_value,
    output logic                                o_out_last,
    output logic                                o_singular
);
    import m4inv_pkg::*;

    logic [ELEM_W-1:0]        r_store [16];
    logic [COF_W-1:0]         r_adj [16];
    logic [3:0]               r_load;
    logic                     r_busy;
    logic [PC_W-1:0]          r_pc;
    logic [PC_W-1:0]          n_pc;
    logic [3:0]               r_ci;
    logic [2:0]               r_k;
    logic [4:0]               r_d;
    logic signed [ELEM_W-1:0] r_a;
    logic [63:0]              r_prod;
    logic signed [65:0]       r_m;
    logic [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]         r_det;
    logic                     r_dneg;
    logic                     r_zero;
    logic [REM_W-1:0]         r_rem;
    logic                     r_nneg;
    logic                     r_sat;
    logic [ELEM_W-1:0]        r_q;

    t_ucode                   uc;
    logic                     accept;
    logic [3:0]               st_addr;
    logic [ELEM_W-1:0]        st_data;
    logic [3:0]               adj_addr;
    logic [COF_W-1:0]         adj_data;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [65:0]       mul_p;
    logic [ACC_W-1:0]         addend;
    logic                     jump;
    logic [COF_W-1:0]         adj_mag;
    logic [REM_W-1:0]         rem_sh;
    logic                     div_bit;
    logic                     neg;
    logic [ELEM_W-1:0]        limit;
    logic [ELEM_W-1:0]        val;

    assign uc     = f_ucode(r_pc);
    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_comb begin
        unique case (uc.adr)
            ADR_S0:  st_addr = f_addr(r_ci, r_k, 2'd0);
            ADR_S1:  st_addr = f_addr(r_ci, r_k, 2'd1);
            ADR_S2:  st_addr = f_addr(r_ci, r_k, 2'd2);
            ADR_K:   st_addr = {2'b00, r_k[1:0]};
            default: st_addr = '0;
        endcase
    end
    assign st_data  = r_store[st_addr];
    assign adj_addr = (uc.opa == OPA_ADJ0 || uc.opa == OPA_ADJ1 || uc.opa == OPA_ADJ2)
                      ? {r_k[1:0], 2'b00} : r_ci;
    assign adj_data = r_adj[adj_addr];

    always_comb begin
        unique case (uc.opa)
            OPA_A:    mul_a = {r_a[ELEM_W-1], r_a};
            OPA_PLO:  mul_a = {1'b0, r_prod[31:0]};
            OPA_PHI:  mul_a = {r_prod[63], r_prod[63:32]};
            OPA_ADJ0: mul_a = {1'b0, adj_data[31:0]};
            OPA_ADJ1: mul_a = {1'b0, adj_data[63:32]};
            OPA_ADJ2: mul_a = adj_data[96:64];
            default:  mul_a = '0;
        endcase
    end
    assign mul_b = {st_data[ELEM_W-1], st_data};
    assign mul_p = mul_a * mul_b;

    always_comb begin
        unique case (uc.sh)
            SH_32:   addend = {{(ACC_W-66){r_m[65]}}, r_m} << 32;
            SH_64:   addend = {{(ACC_W-66){r_m[65]}}, r_m} << 64;
            default: addend = {{(ACC_W-66){r_m[65]}}, r_m};
        endcase
    end

    always_comb begin
        unique case (uc.jmp)
            J_K5:    jump = (r_k != 3'd5);
            J_K3:    jump = (r_k != 3'd3);
            J_CI:    jump = (r_ci != 4'd15);
            J_D:     jump = (r_d != 5'd31);
            J_ZERO:  jump = r_zero;
            default: jump = 1'b0;
        endcase
        n_pc = jump ? uc.target : r_pc + 5'd1;
    end

    assign adj_mag = adj_data[COF_W-1] ? (~adj_data + 1'b1) : adj_data;
    assign rem_sh  = {r_rem[REM_W-2:0], 1'b0};
    assign div_bit = (rem_sh >= {1'b0, r_det});
    assign neg     = r_nneg ^ r_dneg;
    assign limit   = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign val     = (!r_sat && r_q <= limit) ? r_q : limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= '0;
            r_busy  <= 1'b0;
            r_pc    <= '0;
            r_ci    <= '0;
            r_k     <= '0;
            r_d     <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (accept) begin
                r_load <= r_load + 4'd1;
                if (r_load == 4'd15) begin
                    r_busy <= 1'b1;
                    r_pc   <= '0;
                    r_ci   <= '0;
                end
            end
            if (r_busy) begin
                r_pc <= n_pc;
                if (uc.fin && !jump) begin
                    r_busy <= 1'b0;
                end
                if (uc.kop == K_CLR) begin
                    r_k <= '0;
                end else if (uc.kop == K_INC) begin
                    r_k <= r_k + 3'd1;
                end
                if (uc.ci_inc) begin
                    r_ci <= r_ci + 4'd1;
                end
                if (uc.d_clr) begin
                    r_d <= '0;
                end else if (uc.d_inc) begin
                    r_d <= r_d + 5'd1;
                end
                if (uc.op == OP_EMIT) begin
                    o_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store[r_load] <= i_elem_value;
        end
        if (r_busy) begin
            if (uc.mdst == MD_PROD) begin
                r_prod <= mul_p[63:0];
            end else if (uc.mdst == MD_M) begin
                r_m <= mul_p;
            end
            case (uc.acc)
                AC_CLR:  r_acc <= '0;
                AC_TERM: r_acc <= f_term_neg(r_ci, r_k) ? r_acc - addend : r_acc + addend;
                AC_ADD:  r_acc <= r_acc + addend;
                default: r_acc <= r_acc;
            endcase
            case (uc.op)
                OP_LDA: begin
                    r_a <= st_data;
                end
                OP_STC: begin
                    r_adj[r_ci] <= r_acc[COF_W-1:0];
                end
                OP_DET: begin
                    r_dneg <= r_acc[ACC_W-1];
                    r_zero <= (r_acc == '0);
                    r_det  <= r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
                end
                OP_NLD: begin
                    r_nneg <= adj_data[COF_W-1];
                    r_rem  <= {{(REM_W-COF_W){1'b0}}, adj_mag};
                    r_q    <= '0;
                end
                OP_OVF: begin
                    r_sat <= (r_rem >= {1'b0, r_det});
                end
                OP_DIV: begin
                    r_rem <= div_bit ? rem_sh - {1'b0, r_det} : rem_sh;
                    r_q   <= {r_q[ELEM_W-2:0], div_bit};
                end
                OP_EMIT: begin
                    o_out_last  <= (r_ci == 4'd15);
                    o_singular  <= r_zero;
                    o_out_value <= r_zero ? '0 : (neg ? (~val + 1'b1) : val);
                end
                default: begin
                end
            endcase
        end
    end

endmodule
